### hdl/tvi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvi_pkg
// Shared types, sizes and helpers for the tensor value interning block.
// ----------------------------------------------------------------------------
package tvi_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int TENSOR_WORDS = 9;
    localparam int COMP_W       = 64;
    localparam int TENSOR_W     = TENSOR_WORDS * COMP_W;
    localparam int ADDR_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W        = 8;

    typedef logic [TENSOR_W-1:0] t_tensor;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [CNT_W-1:0]    t_count;

    typedef struct packed {
        logic              start_of_set;
        logic [COMP_W-1:0] comp_00;
        logic [COMP_W-1:0] comp_01;
        logic [COMP_W-1:0] comp_02;
        logic [COMP_W-1:0] comp_10;
        logic [COMP_W-1:0] comp_11;
        logic [COMP_W-1:0] comp_12;
        logic [COMP_W-1:0] comp_20;
        logic [COMP_W-1:0] comp_21;
        logic [COMP_W-1:0] comp_22;
    } t_item;

    typedef struct packed {
        logic [IDX_W-1:0] entry_index;
        logic             was_new;
        logic             table_full;
    } t_result;

    typedef struct packed {
        logic  rd_en;
        t_addr rd_addr;
        logic  wr_en;
        t_addr wr_addr;
    } t_tbl_req;

    // keep the low index bits of a count, zero extend when the count is narrower
    function automatic logic [IDX_W-1:0] to_index(input t_count v);
        logic [CNT_W+IDX_W-1:0] wide;
        wide = {{IDX_W{1'b0}}, v};
        return wide[IDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

### hdl/tvi_entry_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvi_entry_table
// Entry memory, one tensor per row, with registered read and a bitwise
// compare of the read row against the search key.
// ----------------------------------------------------------------------------
module tvi_entry_table
    import tvi_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_tbl_req i_req,
    input  wire t_tensor  i_wr_data,
    input  wire t_tensor  i_key,
    output logic          o_match
);

    t_tensor r_mem [TABLE_DEPTH];
    t_tensor r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_match = (r_rd_data == i_key);

endmodule
`default_nettype wire

### hdl/tensor_value_interning.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tensor_value_interning
// Dictionary encoder for 3x3 tensors: returns the index of an equal stored
// tensor or stores the tensor as the next entry, or flags a full table.
// ----------------------------------------------------------------------------
// A word is taken when i_start is high and o_busy is low; o_busy then stays
// high until the result is issued. With N entries stored, a hit on entry i
// is issued once entry i has been compared, and a miss once all N entries
// have been compared (at once when the table is empty). The search is
// linear: the entry table has one read port and one 576-bit comparator, so
// one stored entry is examined per cycle. The result is on o_result for
// exactly one cycle, marked by o_result_valid, and cannot be held off; a new
// word may be started in that same cycle. A word with start_of_set set
// empties the table first.
// ----------------------------------------------------------------------------
module tensor_value_interning
    import tvi_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_item i_item,
    output logic       o_busy,
    output logic       o_result_valid,
    output t_result    o_result
);

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state   r_state, n_state;
    t_count   r_count, n_count;
    t_count   r_addr, n_addr;
    t_count   r_cmp_idx, n_cmp_idx;
    logic     r_cmp_vld, n_cmp_vld;
    t_tensor  r_key, n_key;
    t_result  r_res, n_res;
    logic     r_res_vld, n_res_vld;
    t_tbl_req tbl_req;
    logic     match;

    tvi_entry_table u_table (
        .i_clk     (i_clk),
        .i_req     (tbl_req),
        .i_wr_data (r_key),
        .i_key     (r_key),
        .o_match   (match)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_addr    = r_addr;
        n_cmp_idx = r_cmp_idx;
        n_cmp_vld = 1'b0;
        n_key     = r_key;
        n_res     = r_res;
        n_res_vld = 1'b0;
        tbl_req   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_key = {i_item.comp_00, i_item.comp_01, i_item.comp_02,
                             i_item.comp_10, i_item.comp_11, i_item.comp_12,
                             i_item.comp_20, i_item.comp_21, i_item.comp_22};
                    if (i_item.start_of_set) begin
                        n_count = '0;
                    end
                    n_addr  = '0;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_cmp_vld && match) begin
                    n_res     = '{entry_index: to_index(r_cmp_idx),
                                  was_new: 1'b0, table_full: 1'b0};
                    n_res_vld = 1'b1;
                    n_state   = S_IDLE;
                end else if (r_addr == r_count && !r_cmp_vld) begin
                    n_res_vld = 1'b1;
                    n_state   = S_IDLE;
                    if (r_count == t_count'(TABLE_DEPTH)) begin
                        n_res = '{entry_index: '0, was_new: 1'b0, table_full: 1'b1};
                    end else begin
                        tbl_req.wr_en   = 1'b1;
                        tbl_req.wr_addr = r_count[ADDR_W-1:0];
                        n_res   = '{entry_index: to_index(r_count),
                                    was_new: 1'b1, table_full: 1'b0};
                        n_count = r_count + t_count'(1);
                    end
                end else if (r_addr != r_count) begin
                    tbl_req.rd_en   = 1'b1;
                    tbl_req.rd_addr = r_addr[ADDR_W-1:0];
                    n_cmp_idx = r_addr;
                    n_cmp_vld = 1'b1;
                    n_addr    = r_addr + t_count'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_addr    <= '0;
            r_cmp_vld <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_addr    <= n_addr;
            r_cmp_vld <= n_cmp_vld;
            r_res_vld <= n_res_vld;
        end
        r_cmp_idx <= n_cmp_idx;
        r_key     <= n_key;
        r_res     <= n_res;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_res_vld;
    assign o_result       = r_res;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy not raised after start");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |-> !(r_res.was_new && r_res.table_full))
        else $error("new and full flagged together");

    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && r_res.table_full) |-> (r_count == t_count'(TABLE_DEPTH)))
        else $error("full reported with free entries");

    a_cmp_only_searching: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_state == S_SEARCH && r_cmp_idx < r_count))
        else $error("compare outside search or beyond stored entries");

endmodule
`default_nettype wire
